### design/first_fit_page_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// first fit page allocator assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// property holds at every edge outside reset
`define FFPA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ffpa assertion failed");

// condition implies the consequence in the following cycle
`define FFPA_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("ffpa assertion failed");

`endif

### design/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// first fit page allocator package
// sizes, command and status codes, page entry and sequencer state types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

   localparam int PAGES  = 1024;
   localparam int PAGE_W = 10;
   localparam int CNT_W  = 11;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_NOFIT = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   typedef struct packed {
      logic             free;
      logic [CNT_W-1:0] len;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHK_RD,
      S_CHK_EV,
      S_SET,
      S_FWD_RD,
      S_FWD_EV,
      S_BWD_RD,
      S_BWD_EV,
      S_BASE_WR,
      S_ALC_RD,
      S_ALC_EV,
      S_ALC_WR,
      S_ALC_TAIL,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

### design/first_fit_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// first fit page allocator unit
// page table in one single port memory, walked by a read-modify-write sequencer
// ----------------------------------------------------------------------------
// Manages 1024 pages with a free flag per page and a block length at each free
// block head. After reset a clearing pass over all 1024 pages runs before the
// first word is taken. One word is handled at a time and gives one result
// word. Each page visited is read from memory, then evaluated, and each page
// written takes a memory write: add and free check the pages in the range and
// then mark them free, free also reads the next block head and walks backward
// over free pages to merge; allocate scans pages up to the fitting head and
// then writes count pages. The walks are serial, set by the single memory port.
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_page_allocator_unit_macros.svh"

module first_fit_page_allocator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // cmd, page_index, page_count
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // status, alloc_page, free_total
);
   import ffpa_pkg::*;

   entry_type mem [PAGES];
   entry_type rd_ff;
   logic [PAGE_W-1:0] mem_addr;
   logic              mem_we;
   entry_type         mem_wdata;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [PAGE_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [PAGE_W-1:0] hit_ff, hit_in;
   logic [CNT_W-1:0]  free_ff, free_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_data_ff, rsp_data_in;

   cmd_type           req_cmd;
   logic [PAGE_W-1:0] req_page;
   logic [CNT_W-1:0]  req_cnt;
   logic [CNT_W:0]    req_end;
   logic              accept;
   logic [CNT_W-1:0]  ptr_next;
   logic              last_page;

   assign req_cmd   = cmd_type'(req_tdata[1:0]);
   assign req_page  = req_tdata[11:2];
   assign req_cnt   = req_tdata[22:12];
   assign req_end   = {2'b00, req_page} + {1'b0, req_cnt};
   assign accept    = req_tvalid && req_tready;
   assign ptr_next  = ptr_ff + CNT_W'(1);
   assign last_page = (ptr_next == end_ff);

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   // next state and sequencer registers
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      ptr_in       = ptr_ff;
      head_in      = head_ff;
      len_in       = len_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            ptr_in = ptr_next;
            if (ptr_ff == CNT_W'(PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_cmd;
               base_in   = req_page;
               cnt_in    = req_cnt;
               end_in    = req_end[CNT_W-1:0];
               hit_in    = '0;
               status_in = ST_BAD;
               priority if (req_cnt == '0 || req_cmd == CMD_NONE) begin
                  state_in = S_RESP;
               end else if (req_cmd == CMD_ALLOC) begin
                  status_in = ST_NOFIT;
                  ptr_in    = '0;
                  state_in  = (req_cnt > free_ff) ? S_RESP : S_ALC_RD;
               end else if (req_end > (CNT_W+1)'(PAGES)) begin
                  state_in = S_RESP;
               end else begin
                  ptr_in   = {1'b0, req_page};
                  state_in = S_CHK_RD;
               end
            end
         end
         S_CHK_RD: state_in = S_CHK_EV;
         S_CHK_EV: begin
            priority if (rd_ff.free) begin
               state_in = S_RESP;
            end else if (last_page) begin
               ptr_in   = {1'b0, base_ff};
               state_in = S_SET;
            end else begin
               ptr_in   = ptr_next;
               state_in = S_CHK_RD;
            end
         end
         S_SET: begin
            ptr_in = ptr_next;
            if (last_page) begin
               head_in = cnt_ff;
               priority if (cmd_ff == CMD_ADD) begin
                  free_in   = free_ff + cnt_ff;
                  status_in = ST_DONE;
                  state_in  = S_RESP;
               end else if (end_ff < CNT_W'(PAGES)) begin
                  state_in = S_FWD_RD;
               end else if (base_ff == '0) begin
                  state_in = S_BASE_WR;
               end else begin
                  ptr_in   = {1'b0, base_ff} - CNT_W'(1);
                  state_in = S_BWD_RD;
               end
            end
         end
         S_FWD_RD: state_in = S_FWD_EV;
         S_FWD_EV: begin
            if (rd_ff.free) begin
               head_in = head_ff + rd_ff.len;
            end
            if (base_ff == '0) begin
               state_in = S_BASE_WR;
            end else begin
               ptr_in   = {1'b0, base_ff} - CNT_W'(1);
               state_in = S_BWD_RD;
            end
         end
         S_BWD_RD: state_in = S_BWD_EV;
         S_BWD_EV: begin
            priority if (!rd_ff.free) begin
               state_in = S_BASE_WR;
            end else if (rd_ff.len != '0) begin
               head_in  = '0;
               state_in = S_BASE_WR;
            end else if (ptr_ff == '0) begin
               state_in = S_BASE_WR;
            end else begin
               ptr_in   = ptr_ff - CNT_W'(1);
               state_in = S_BWD_RD;
            end
         end
         S_BASE_WR: begin
            free_in   = free_ff + cnt_ff;
            status_in = ST_DONE;
            state_in  = S_RESP;
         end
         S_ALC_RD: state_in = S_ALC_EV;
         S_ALC_EV: begin
            priority if (rd_ff.free && rd_ff.len >= cnt_ff) begin
               hit_in   = ptr_ff[PAGE_W-1:0];
               len_in   = rd_ff.len;
               end_in   = ptr_ff + cnt_ff;
               state_in = S_ALC_WR;
            end else if (ptr_ff == CNT_W'(PAGES - 1)) begin
               state_in = S_RESP;
            end else begin
               ptr_in   = ptr_next;
               state_in = S_ALC_RD;
            end
         end
         S_ALC_WR: begin
            ptr_in = ptr_next;
            if (last_page || ptr_ff == CNT_W'(PAGES - 1)) begin
               if (len_ff > cnt_ff && end_ff < CNT_W'(PAGES)) begin
                  state_in = S_ALC_TAIL;
               end else begin
                  free_in   = free_ff - cnt_ff;
                  status_in = ST_DONE;
                  state_in  = S_RESP;
               end
            end
         end
         S_ALC_TAIL: begin
            free_in   = free_ff - cnt_ff;
            status_in = ST_DONE;
            state_in  = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {1'b0, free_ff,
                            (status_ff == ST_DONE) ? hit_ff : PAGE_W'(0), status_ff};
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory port
   always_comb begin
      mem_addr  = ptr_ff[PAGE_W-1:0];
      mem_we    = 1'b0;
      mem_wdata = '0;
      unique case (state_ff)
         S_CLEAR: mem_we = 1'b1;
         S_SET: begin
            mem_we         = 1'b1;
            mem_wdata.free = 1'b1;
            mem_wdata.len  = (ptr_ff[PAGE_W-1:0] == base_ff) ? cnt_ff : '0;
         end
         S_FWD_RD: mem_addr = end_ff[PAGE_W-1:0];
         S_FWD_EV: begin
            mem_addr       = end_ff[PAGE_W-1:0];
            mem_we         = rd_ff.free;
            mem_wdata.free = 1'b1;
         end
         S_BWD_EV: begin
            mem_we         = rd_ff.free && (rd_ff.len != '0);
            mem_wdata.free = 1'b1;
            mem_wdata.len  = rd_ff.len + head_ff;
         end
         S_BASE_WR: begin
            mem_addr       = base_ff;
            mem_we         = 1'b1;
            mem_wdata.free = 1'b1;
            mem_wdata.len  = head_ff;
         end
         S_ALC_WR: mem_we = 1'b1;
         S_ALC_TAIL: begin
            mem_addr       = end_ff[PAGE_W-1:0];
            mem_we         = 1'b1;
            mem_wdata.free = 1'b1;
            mem_wdata.len  = len_ff - cnt_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      base_ff     <= base_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      head_ff     <= head_in;
      len_ff      <= len_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   `FFPA_ASSERT(a_free_bound, clock, reset, free_ff <= CNT_W'(PAGES))
   `FFPA_ASSERT(a_no_write_idle, clock, reset, !(state_ff == S_IDLE && mem_we))
   `FFPA_ASSERT(a_accept_no_pending, clock, reset, !(accept && rsp_valid_ff))
   `FFPA_ASSERT_NEXT(a_resp_raises, clock, reset, state_ff == S_RESP, rsp_valid_ff)

endmodule

`default_nettype wire
